### hdl/rme_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies.
package rme_pkg;

  localparam logic [1:0] REG_MODULUS  = 2'd0;
  localparam logic [1:0] REG_PUB_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIV_EXP = 2'd2;

  localparam int unsigned RESET_PUB_EXP = 3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_STEP = 5'b00100,
    S_MUL  = 5'b01000,
    S_SQR  = 5'b10000
  } rme_state_t;

endpackage

### hdl/rme_cell.sv
// One bit cell of the multiplier shift chain.
// Depends on nothing.
module rme_cell (
  input  logic clk,
  input  logic load,
  input  logic ld_bit,
  input  logic shift_in,
  output logic q
);

  logic q_r;

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= ld_bit;
    end else begin
      q_r <= shift_in;
    end
  end

  assign q = q_r;

endmodule

### hdl/rme_mulmod.sv
// Interleaved shift-add modular multiplier, one multiplier bit per cycle.
// Depends on rme_pkg and rme_cell.
module rme_mulmod #(
  parameter int MOD_BITS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MOD_BITS-1:0] op_a,
  input  logic [MOD_BITS-1:0] op_b,
  input  logic [MOD_BITS-1:0] modn,
  output logic [MOD_BITS-1:0] res,
  output rme_pkg::mm_stat_t   stat
);

  localparam int CW = $clog2(MOD_BITS + 1);

  logic [MOD_BITS-1:0] chain;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] b_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [MOD_BITS+1:0] t0, t1, t2, nx;

  genvar g;
  generate
    for (g = 0; g < MOD_BITS; g++) begin : g_cell
      if (g == 0) begin : g_first
        rme_cell u_cell (.clk(clk), .load(start), .ld_bit(op_a[g]),
                         .shift_in(1'b0), .q(chain[g]));
      end else begin : g_rest
        rme_cell u_cell (.clk(clk), .load(start), .ld_bit(op_a[g]),
                         .shift_in(chain[g-1]), .q(chain[g]));
      end
    end
  endgenerate

  always_comb begin
    nx = {2'b00, modn};
    t0 = {1'b0, acc_r, 1'b0} + (chain[MOD_BITS-1] ? {2'b00, b_r} : '0);
    t1 = (t0 >= nx) ? t0 - nx : t0;
    t2 = (t1 >= nx) ? t1 - nx : t1;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = t2[MOD_BITS-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(MOD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (start) begin
      b_r <= op_b;
    end
  end

  assign res       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### hdl/rsa_modular_exponentiation.sv
// Top level: config registers, square-and-multiply sequencer, output register.
// Depends on rme_pkg and rme_mulmod.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | tdata: message, tuser: opcode
//  out     | out | out_tvalid/tready  | tdata: result
//  cfg     | in  | cfg_valid/ready    | cfg_addr, cfg_data
//
// A word is first reduced mod n; then each exponent bit gets a squaring, plus a
// multiply when the bit is set, on the bit-serial multiplier. When n <= 1 the
// result is 0 and no multiply is run.
// One word in flight; the output register holds a result while the next runs.
// Synchronous active-low reset; cfg_ready is always high.
module rsa_modular_exponentiation #(
  parameter int MOD_BITS = 14,
  parameter int EXP_BITS = 20
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((MOD_BITS+7)/8)*8-1:0]       in_tdata,   // message
  input  logic                                in_tuser,   // opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((MOD_BITS+7)/8)*8-1:0]       out_tdata,  // result
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_addr,
  input  logic [((EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS)-1:0] cfg_data
);

  localparam int DW = ((MOD_BITS + 7) / 8) * 8;
  localparam int CNW = $clog2(EXP_BITS + 1);

  logic [MOD_BITS-1:0] modulus_r, pub_r;
  logic [EXP_BITS-1:0] priv_r;

  rme_pkg::rme_state_t state_r, state_nxt;
  logic [MOD_BITS-1:0] n_r, acc_r, acc_nxt, base_r, base_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [CNW-1:0]      cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic                outv_r, outv_nxt;
  logic [MOD_BITS-1:0] outd_r, outd_nxt;

  logic                mm_start;
  logic [MOD_BITS-1:0] mm_a, mm_b, mm_res;
  rme_pkg::mm_stat_t   mm_stat;
  logic                in_acc;
  logic [MOD_BITS-1:0] msg;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == rme_pkg::S_IDLE) && !done_r;
  assign in_acc    = in_tvalid && in_tready;
  assign msg       = in_tdata[MOD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_BITS'(1);
      pub_r     <= MOD_BITS'(rme_pkg::RESET_PUB_EXP);
      priv_r    <= EXP_BITS'(1);
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        rme_pkg::REG_MODULUS:  modulus_r <= cfg_data[MOD_BITS-1:0];
        rme_pkg::REG_PUB_EXP:  pub_r     <= cfg_data[MOD_BITS-1:0];
        rme_pkg::REG_PRIV_EXP: priv_r    <= cfg_data[EXP_BITS-1:0];
        default: ;
      endcase
    end
  end

  rme_mulmod #(.MOD_BITS(MOD_BITS)) u_mm (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .op_a(mm_a), .op_b(mm_b),
    .modn(n_r), .res(mm_res), .stat(mm_stat)
  );

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    outv_nxt  = outv_r && !out_tready;
    outd_nxt  = outd_r;
    mm_start  = 1'b0;
    mm_a      = base_r;
    mm_b      = base_r;
    if (done_r && !outv_nxt) begin
      outv_nxt = 1'b1;
      outd_nxt = acc_r;
      done_nxt = 1'b0;
    end
    unique case (state_r)
      rme_pkg::S_IDLE: begin
        if (in_acc) begin
          exp_nxt = (in_tuser == rme_pkg::OP_DECRYPT) ? priv_r
                                                      : EXP_BITS'(pub_r);
          cnt_nxt = '0;
          if (modulus_r <= MOD_BITS'(1)) begin
            acc_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            mm_start  = 1'b1;
            mm_a      = msg;
            mm_b      = MOD_BITS'(1);
            state_nxt = rme_pkg::S_RED;
          end
        end
      end
      rme_pkg::S_RED: begin
        if (mm_stat.done) begin
          base_nxt  = mm_res;
          acc_nxt   = MOD_BITS'(1);
          state_nxt = rme_pkg::S_STEP;
        end
      end
      rme_pkg::S_STEP: begin
        if (cnt_r == CNW'(EXP_BITS)) begin
          done_nxt  = 1'b1;
          state_nxt = rme_pkg::S_IDLE;
        end else if (exp_r[0]) begin
          mm_start  = 1'b1;
          mm_a      = acc_r;
          state_nxt = rme_pkg::S_MUL;
        end else begin
          mm_start  = 1'b1;
          state_nxt = rme_pkg::S_SQR;
        end
      end
      rme_pkg::S_MUL: begin
        if (mm_stat.done) begin
          acc_nxt   = mm_res;
          mm_start  = 1'b1;
          state_nxt = rme_pkg::S_SQR;
        end
      end
      rme_pkg::S_SQR: begin
        if (mm_stat.done) begin
          base_nxt  = mm_res;
          exp_nxt   = exp_r >> 1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = rme_pkg::S_STEP;
        end
      end
      default: state_nxt = rme_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rme_pkg::S_IDLE;
      done_r  <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
    outd_r <= outd_nxt;
    if (in_acc) begin
      n_r <= modulus_r;
    end
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = DW'(outd_r);

endmodule

### hdl/rme_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top.
// Depends on rsa_modular_exponentiation.
module rme_checker #(
  parameter int DW = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [DW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in work");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

endmodule

bind rsa_modular_exponentiation rme_checker #(.DW(((MOD_BITS+7)/8)*8)) u_rme_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

### sim/rsa_modular_exponentiation_test.sv
// Testbench for rsa_modular_exponentiation: directed and random words checked
// against a square-and-multiply predictor kept in a small scoreboard class.
// Depends on rme_pkg and the block's RTL only.
module rsa_modular_exponentiation_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MB = 14;
  localparam int EB = 20;

  class power_board;
    logic [MB-1:0] modulus;
    logic [MB-1:0] pub_exp;
    logic [EB-1:0] priv_exp;
    logic [MB-1:0] pending[$];
    int errors;
    int checked;

    function new();
      modulus = 1;
      pub_exp = MB'(rme_pkg::RESET_PUB_EXP);
      priv_exp = 1;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [EB-1:0] val);
      if (idx == rme_pkg::REG_MODULUS) modulus = val[MB-1:0];
      else if (idx == rme_pkg::REG_PUB_EXP) pub_exp = val[MB-1:0];
      else if (idx == rme_pkg::REG_PRIV_EXP) priv_exp = val;
    endfunction

    function logic [MB-1:0] power_mod(logic [MB-1:0] msg, logic [EB-1:0] ex);
      longint unsigned b, acc, n;
      n = modulus;
      if (n <= 1) return '0;
      b = msg % n;
      acc = 1;
      for (int i = 0; i < EB; i++) begin
        if (ex[i]) acc = (acc * b) % n;
        b = (b * b) % n;
      end
      return acc[MB-1:0];
    endfunction

    function void note_word(logic op, logic [MB-1:0] msg);
      logic [EB-1:0] ex;
      ex = (op == rme_pkg::OP_DECRYPT) ? priv_exp : {6'd0, pub_exp};
      pending.push_back(power_mod(msg, ex));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_word(logic [MB-1:0] got);
      logic [MB-1:0] want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) report($sformatf("result %0d, expected %0d", got, want));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0;
  logic [15:0] in_tdata = '0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [15:0] out_tdata;
  logic cfg_valid = 0;
  logic [1:0] cfg_addr = '0;
  logic [EB-1:0] cfg_data = '0;

  power_board sb = new();
  int send_idle = 27, recv_idle = 67;
  int sent = 0;
  longint cycles = 0;

  rsa_modular_exponentiation i_dut (.*);

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata[MB-1:0]);
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task send_word(logic op, logic [MB-1:0] msg);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {2'b00, msg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(op, msg);
    sent++;
  endtask

  task drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [EB-1:0] val);
    cfg_valid <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task setup(logic [MB-1:0] n, logic [MB-1:0] e, logic [EB-1:0] d);
    drain();
    write_reg(rme_pkg::REG_MODULUS, EB'(n));
    write_reg(rme_pkg::REG_PUB_EXP, EB'(e));
    write_reg(rme_pkg::REG_PRIV_EXP, d);
  endtask

  task random_words(int count, int msg_max);
    for (int i = 0; i < count; i++) begin
      send_word(1'($urandom_range(1)), MB'($urandom_range(msg_max)));
      if ($urandom_range(40) == 0) drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset registers: n = 1 gives zero
    send_word(rme_pkg::OP_ENCRYPT, 14'h3fff);
    send_word(rme_pkg::OP_DECRYPT, 5);
    setup(3233, 17, 2753);
    send_word(rme_pkg::OP_ENCRYPT, 65);
    send_word(rme_pkg::OP_DECRYPT, 2790);
    send_word(rme_pkg::OP_ENCRYPT, 0);
    send_word(rme_pkg::OP_ENCRYPT, 14'h3fff);
    send_word(rme_pkg::OP_DECRYPT, 3233);
    setup(16383, 0, 0);
    send_word(rme_pkg::OP_ENCRYPT, 0);
    send_word(rme_pkg::OP_DECRYPT, 0);
    send_word(rme_pkg::OP_ENCRYPT, 16382);
    setup(16383, 16383, 20'hfffff);
    send_word(rme_pkg::OP_ENCRYPT, 16382);
    send_word(rme_pkg::OP_DECRYPT, 12345);
    send_word(rme_pkg::OP_DECRYPT, 14'h2aaa);
    send_word(rme_pkg::OP_ENCRYPT, 14'h1555);
    drain();
    write_reg(2'd3, 20'h12345);
    write_reg(rme_pkg::REG_MODULUS, 0);
    send_word(rme_pkg::OP_ENCRYPT, 7);
    send_word(rme_pkg::OP_DECRYPT, 9);
    setup(2, 1, 1);
    send_word(rme_pkg::OP_ENCRYPT, 3);
    send_word(rme_pkg::OP_DECRYPT, 2);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle = 67; recv_idle = 27; end
      if (phase == 2) begin send_idle = 0; recv_idle = 0; end
      for (int k = 0; k < 5; k++) begin
        setup(MB'($urandom_range(16383, 1)), MB'($urandom_range(16383)),
              EB'($urandom_range(20'hfffff)));
        random_words(60, 16383);
      end
      setup(MB'(1 + $urandom_range(15)), MB'($urandom_range(16383)),
            EB'($urandom_range(20'hfffff)));
      random_words(10, 16383);
    end
    drain();
    repeat (700) @(posedge clk);
    $display("covered %0d words over modulus, exponent and idle settings, %0d results",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
